/* rtl/core/qs_pkg.sv */
`default_nettype none

package qs_pkg;

  // Element word carried in and out of the sorter
  localparam int unsigned ValueWidth = 32;

  typedef logic signed [ValueWidth-1:0] value_t;

endpackage

`default_nettype wire

/* rtl/core/qs_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data
module qs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on enable
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data, hold it while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/quicksort_sorter_top.sv */
// Channel  | Handshake                   | Word
// ---------+-----------------------------+----------------------------------------
// input    | start_i high, busy_o low    | value_i, last_i
// result   | valid_o strobe, one cycle   | sorted_value_o, end_of_run_o, overflow_o
//
// Loading takes one cycle per word; busy_o stays low until a word with last_i.
// The sort then runs on the element store, at most one memory access per cycle:
// each scanned element is read and compared, each swap writes two elements, and
// each partition pops a range, places its pivot and pushes parts of two or more
// elements. Results then stream one per cycle and cannot be stalled.
// Reset is asynchronous, active low, and clears count, flags and state; the
// memories need no clearing.
`default_nettype none

module quicksort_sorter_top #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire qs_pkg::value_t value_i,
  input  wire logic           last_i,
  output logic                valid_o,
  output qs_pkg::value_t      sorted_value_o,
  output logic                end_of_run_o,
  output logic                overflow_o
);

  import qs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SW = 2 * IW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_POP     = 4'd2;
  localparam logic [3:0] S_POPW    = 4'd3;
  localparam logic [3:0] S_PIVW    = 4'd4;
  localparam logic [3:0] S_SCANRD  = 4'd5;
  localparam logic [3:0] S_SCANCMP = 4'd6;
  localparam logic [3:0] S_SWAP1   = 4'd7;
  localparam logic [3:0] S_SWAP2   = 4'd8;
  localparam logic [3:0] S_FINRD   = 4'd9;
  localparam logic [3:0] S_FINW1   = 4'd10;
  localparam logic [3:0] S_FINW2   = 4'd11;
  localparam logic [3:0] S_PUSH1   = 4'd12;
  localparam logic [3:0] S_PUSH2   = 4'd13;
  localparam logic [3:0] S_OUT     = 4'd14;
  localparam logic [3:0] S_DONE    = 4'd15;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d, m_q, m_d, i_q, i_d, k_q, k_d;
  value_t        pivot_q, pivot_d, ai_q, ai_d;
  logic          out_pend_q, out_pend_d, out_last_q, out_last_d;

  // Element store port signals
  logic          s_we, s_re;
  logic [IW-1:0] s_waddr, s_raddr;
  value_t        s_wdata, s_rdata;

  // Range stack port signals
  logic          r_we, r_re;
  logic [IW-1:0] r_waddr, r_raddr;
  logic [SW-1:0] r_wdata, r_rdata;

  logic [CW-1:0] cnt_m1, sp_m1;
  logic [IW:0]   m_ext, lo_ext, hi_ext;

  assign cnt_m1 = CW'(count_q - 1'b1);
  assign sp_m1  = CW'(sp_q - 1'b1);
  assign m_ext  = {1'b0, m_q};
  assign lo_ext = {1'b0, lo_q};
  assign hi_ext = {1'b0, hi_q};

  qs_ram #(
    .WIDTH(ValueWidth),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .re_i   (s_re),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  qs_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_ELEMENTS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(r_waddr),
    .wdata_i(r_wdata),
    .re_i   (r_re),
    .raddr_i(r_raddr),
    .rdata_o(r_rdata)
  );

  // Load, partition and stream sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    dropped_d  = dropped_q;
    sp_d       = sp_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    m_d        = m_q;
    i_d        = i_q;
    k_d        = k_q;
    pivot_d    = pivot_q;
    ai_d       = ai_q;
    out_pend_d = 1'b0;
    out_last_d = 1'b0;
    s_we       = 1'b0;
    s_waddr    = m_q;
    s_wdata    = value_i;
    s_re       = 1'b0;
    s_raddr    = i_q;
    r_we       = 1'b0;
    r_waddr    = sp_q[IW-1:0];
    r_wdata    = {lo_q, hi_q};
    r_re       = 1'b0;
    r_raddr    = sp_m1[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          // Store the word while room is left, else drop it and flag
          if (count_q < CW'(MAX_ELEMENTS)) begin
            s_we    = 1'b1;
            s_waddr = count_q[IW-1:0];
            s_wdata = value_i;
            count_d = CW'(count_q + 1'b1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        k_d = '0;
        if (count_q < CW'(2)) begin
          state_d = S_OUT;
        end else begin
          // Push the whole set as the first range
          r_we    = 1'b1;
          r_waddr = '0;
          r_wdata = {IW'(0), cnt_m1[IW-1:0]};
          sp_d    = CW'(1);
          state_d = S_POP;
        end
      end
      S_POP: begin
        k_d = '0;
        if (sp_q == '0) begin
          state_d = S_OUT;
        end else begin
          r_re    = 1'b1;
          sp_d    = sp_m1;
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        // Unpack range, fetch the pivot at its low end
        lo_d    = r_rdata[SW-1:IW];
        hi_d    = r_rdata[IW-1:0];
        m_d     = r_rdata[SW-1:IW];
        i_d     = IW'(r_rdata[SW-1:IW] + 1'b1);
        s_re    = 1'b1;
        s_raddr = r_rdata[SW-1:IW];
        state_d = S_PIVW;
      end
      S_PIVW: begin
        pivot_d = s_rdata;
        state_d = S_SCANRD;
      end
      S_SCANRD: begin
        s_re    = 1'b1;
        s_raddr = i_q;
        state_d = S_SCANCMP;
      end
      S_SCANCMP: begin
        ai_d = s_rdata;
        if (s_rdata < pivot_q) begin
          m_d = IW'(m_q + 1'b1);
          if (IW'(m_q + 1'b1) != i_q) begin
            // Fetch the element to swap with
            s_re    = 1'b1;
            s_raddr = IW'(m_q + 1'b1);
            state_d = S_SWAP1;
          end else if (i_q == hi_q) begin
            state_d = S_FINRD;
          end else begin
            i_d     = IW'(i_q + 1'b1);
            state_d = S_SCANRD;
          end
        end else if (i_q == hi_q) begin
          state_d = S_FINRD;
        end else begin
          i_d     = IW'(i_q + 1'b1);
          state_d = S_SCANRD;
        end
      end
      S_SWAP1: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata;
        state_d = S_SWAP2;
      end
      S_SWAP2: begin
        s_we    = 1'b1;
        s_waddr = m_q;
        s_wdata = ai_q;
        if (i_q == hi_q) begin
          state_d = S_FINRD;
        end else begin
          i_d     = IW'(i_q + 1'b1);
          state_d = S_SCANRD;
        end
      end
      S_FINRD: begin
        // Move the pivot into its final slot unless it is already there
        if (m_q == lo_q) begin
          state_d = S_PUSH1;
        end else begin
          s_re    = 1'b1;
          s_raddr = m_q;
          state_d = S_FINW1;
        end
      end
      S_FINW1: begin
        s_we    = 1'b1;
        s_waddr = lo_q;
        s_wdata = s_rdata;
        state_d = S_FINW2;
      end
      S_FINW2: begin
        s_we    = 1'b1;
        s_waddr = m_q;
        s_wdata = pivot_q;
        state_d = S_PUSH1;
      end
      S_PUSH1: begin
        // Push the left part if it holds two or more elements
        if (m_ext > (lo_ext + 1'b1)) begin
          r_we    = 1'b1;
          r_wdata = {lo_q, IW'(m_q - 1'b1)};
          sp_d    = CW'(sp_q + 1'b1);
        end
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        // Push the right part if it holds two or more elements
        if ((m_ext + 1'b1) < hi_ext) begin
          r_we    = 1'b1;
          r_wdata = {IW'(m_q + 1'b1), hi_q};
          sp_d    = CW'(sp_q + 1'b1);
        end
        state_d = S_POP;
      end
      S_OUT: begin
        // Stream the store in order, one word per cycle
        s_re       = 1'b1;
        s_raddr    = k_q;
        out_pend_d = 1'b1;
        out_last_d = (k_q == cnt_m1[IW-1:0]);
        if (k_q == cnt_m1[IW-1:0]) begin
          state_d = S_DONE;
        end else begin
          k_d = IW'(k_q + 1'b1);
        end
      end
      S_DONE: begin
        // Last word is on the ports; clear for the next set
        count_d   = '0;
        dropped_d = 1'b0;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      dropped_q  <= 1'b0;
      sp_q       <= '0;
      out_pend_q <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      dropped_q  <= dropped_d;
      sp_q       <= sp_d;
      out_pend_q <= out_pend_d;
      out_last_q <= out_last_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    m_q     <= m_d;
    i_q     <= i_d;
    k_q     <= k_d;
    pivot_q <= pivot_d;
    ai_q    <= ai_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign valid_o        = out_pend_q;
  assign sorted_value_o = s_rdata;
  assign end_of_run_o   = out_last_q;
  assign overflow_o     = dropped_q;

endmodule

`default_nettype wire

/* rtl/core/qs_checker.sv */
`default_nettype none

module qs_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start_i,
  input wire logic           busy_o,
  input wire logic           last_i,
  input wire logic           valid_o,
  input wire qs_pkg::value_t sorted_value_o,
  input wire logic           end_of_run_o
);

  import qs_pkg::*;

  // Results appear only while the sorter is busy
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result word while idle");

  // Run end is followed by a gap
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && end_of_run_o) |=> !valid_o)
    else $error("result word after end of run");

  // A word without last keeps the sorter ready for loading
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_i) |=> !busy_o)
    else $error("busy after a non-final word");

  // A final word starts the sort
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("not busy after the final word");

  // Results within one run come out in ascending order
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(valid_o) && !$past(end_of_run_o))
      |-> (sorted_value_o >= $past(sorted_value_o)))
    else $error("result words out of order");

endmodule

bind quicksort_sorter_top qs_checker u_qs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .last_i        (last_i),
  .valid_o       (valid_o),
  .sorted_value_o(sorted_value_o),
  .end_of_run_o  (end_of_run_o)
);

`default_nettype wire

/* dv/quicksort_sorter_top_test.sv */
`default_nettype none

module quicksort_sorter_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import qs_pkg::*;

  localparam int unsigned MaxElements = 64;
  localparam time         ClockPeriod = 20ns;
  localparam int          RandomWords = 330;
  localparam int          StallLimit  = 100000;
  localparam int          TailCycles  = 80;
  // Words accepted in this window see no random sender idling
  localparam int          QuietFrom   = 140;
  localparam int          QuietTo     = 260;

  typedef enum int {
    FillRandom,
    FillNarrow,
    FillAscending,
    FillDescending,
    FillExtremes
  } fill_kind_e;

  typedef struct {
    value_t value;
    logic   last;
    logic   drain;
  } load_word_t;

  typedef struct {
    value_t value;
    logic   end_of_run;
    logic   overflow;
  } sorted_word_t;

  logic   clk_i   = 1'b0;
  logic   rst_ni  = 1'b0;
  logic   start_i = 1'b0;
  value_t value_i = '0;
  logic   last_i  = 1'b0;
  logic   busy_o;
  logic   valid_o;
  value_t sorted_value_o;
  logic   end_of_run_o;
  logic   overflow_o;

  load_word_t   pending_words[$];
  sorted_word_t sorted_words_due[$];

  // Shadow of the set being collected
  value_t set_store [MaxElements];
  int     set_count   = 0;
  logic   set_dropped = 1'b0;

  int   words_loaded = 0;
  int   stall_cycles = 0;
  logic failed       = 1'b0;

  quicksort_sorter_top #(
    .MAX_ELEMENTS(MaxElements)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .valid_o       (valid_o),
    .sorted_value_o(sorted_value_o),
    .end_of_run_o  (end_of_run_o),
    .overflow_o    (overflow_o)
  );

  always #(ClockPeriod / 2) clk_i = ~clk_i;

  // Store or drop one loaded word; on last, sort the set and queue the run
  task automatic absorb_word(input value_t value, input logic last);
    value_t       key;
    int           j;
    sorted_word_t word;
    if (set_count < MaxElements) begin
      set_store[set_count] = value;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      for (int i = 1; i < set_count; i++) begin
        key = set_store[i];
        j   = i - 1;
        while (j >= 0 && set_store[j] > key) begin
          set_store[j + 1] = set_store[j];
          j--;
        end
        set_store[j + 1] = key;
      end
      for (int k = 0; k < set_count; k++) begin
        word.value      = set_store[k];
        word.end_of_run = (k == set_count - 1);
        word.overflow   = set_dropped;
        sorted_words_due.push_back(word);
      end
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic queue_word(input value_t value, input logic last, input logic drain);
    load_word_t word;
    word.value = value;
    word.last  = last;
    word.drain = drain;
    pending_words.push_back(word);
  endtask

  // Queue one set of the given size; the first word may wait for the previous run
  task automatic queue_set(input int size, input fill_kind_e kind, input logic drain);
    value_t value;
    for (int k = 0; k < size; k++) begin
      case (kind)
        FillNarrow:     value = value_t'($urandom_range(12)) - 32'sd6;
        FillAscending:  value = -32'sd1000 + value_t'(k * 7);
        FillDescending: value = 32'sd5000 - value_t'(k * 13);
        FillExtremes: begin
          case ($urandom_range(4))
            0:       value = 32'sh8000_0000;
            1:       value = 32'sh7fff_ffff;
            2:       value = 32'sd0;
            3:       value = -32'sd1;
            default: value = 32'sd1;
          endcase
        end
        default:        value = value_t'($urandom());
      endcase
      queue_word(value, k == size - 1, drain && k == 0);
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    int         random_words;
    int         size;
    int         pick;
    fill_kind_e kind;

    // Directed sets: single elements, extremes, duplicates, pairs
    queue_word(32'sh7fff_ffff, 1'b1, 1'b0);
    queue_word(32'sh8000_0000, 1'b1, 1'b1);
    queue_word(32'sh7fff_ffff, 1'b0, 1'b0);
    queue_word(32'sh8000_0000, 1'b0, 1'b0);
    queue_word(32'sd0, 1'b0, 1'b0);
    queue_word(-32'sd1, 1'b0, 1'b0);
    queue_word(32'sd1, 1'b0, 1'b0);
    queue_word(32'sh8000_0000, 1'b0, 1'b0);
    queue_word(32'sh7fff_ffff, 1'b1, 1'b0);
    queue_set(4, FillNarrow, 1'b0);
    queue_word(32'sd9, 1'b0, 1'b0);
    queue_word(32'sd9, 1'b0, 1'b0);
    queue_word(32'sd9, 1'b1, 1'b0);
    queue_word(32'sd3, 1'b0, 1'b1);
    queue_word(-32'sd3, 1'b1, 1'b0);
    queue_word(-32'sd3, 1'b0, 1'b0);
    queue_word(32'sd3, 1'b1, 1'b0);
    queue_word(32'sh5555_5555, 1'b0, 1'b0);
    queue_word(32'shaaaa_aaaa, 1'b1, 1'b0);

    // Full store without overflow, then last word arriving on a full store
    queue_set(MaxElements, FillAscending, 1'b1);
    queue_set(MaxElements + 2, FillDescending, 1'b0);
    random_words = pending_words.size();

    // Random sets: mostly small, some medium, a few near, at or past capacity
    while (random_words < RandomWords) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        size = $urandom_range(MaxElements + 6, MaxElements - 4);
      end else if (pick < 14) begin
        size = $urandom_range(40, 13);
      end else begin
        size = $urandom_range(12, 1);
      end
      case ($urandom_range(9))
        0, 1:    kind = FillNarrow;
        2:       kind = FillAscending;
        3:       kind = FillDescending;
        4:       kind = FillExtremes;
        default: kind = FillRandom;
      endcase
      queue_set(size, kind, $urandom_range(7) == 0);
      random_words += size;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || start_i || sorted_words_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: hold an offered word until taken, then offer the next or idle
  always @(posedge clk_i) begin
    load_word_t word;
    logic       holding;
    logic       idle;
    if (rst_ni) begin
      holding = start_i;
      if (start_i && !busy_o) begin
        absorb_word(value_i, last_i);
        words_loaded++;
        holding = 1'b0;
      end
      if (!holding) begin
        idle = ($urandom_range(99) < 23) &&
               (words_loaded < QuietFrom || words_loaded >= QuietTo);
        if (pending_words.size() != 0 && !idle &&
            !(pending_words[0].drain && sorted_words_due.size() != 0)) begin
          word = pending_words.pop_front();
          start_i <= 1'b1;
          value_i <= word.value;
          last_i  <= word.last;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest expected one
  always @(posedge clk_i) begin
    sorted_word_t due;
    if (rst_ni) begin
      if (valid_o) begin
        if (sorted_words_due.size() == 0) begin
          $error("result word with none expected: sorted_value %0d", sorted_value_o);
          failed = 1'b1;
        end else begin
          due = sorted_words_due.pop_front();
          if (sorted_value_o !== due.value) begin
            $error("sorted_value: expected %0d, got %0d", due.value, sorted_value_o);
            failed = 1'b1;
          end
          if (end_of_run_o !== due.end_of_run) begin
            $error("end_of_run: expected %0b, got %0b", due.end_of_run, end_of_run_o);
            failed = 1'b1;
          end
          if (overflow_o !== due.overflow) begin
            $error("overflow: expected %0b, got %0b", due.overflow, overflow_o);
            failed = 1'b1;
          end
        end
      end

      // Watchdog: count cycles with no word moving either way
      if (valid_o || (start_i && !busy_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $error("no word moved for %0d cycles", StallLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

/* quicksort_sorter_top.f */
rtl/core/qs_pkg.sv
rtl/core/qs_ram.sv
rtl/core/quicksort_sorter_top.sv
rtl/core/qs_checker.sv
dv/quicksort_sorter_top_test.sv
